### rtl/adpcmb_pkg.sv
package adpcmb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PRED_W   = 18;
    localparam int DIFF_W   = 19;
    localparam int MAG_W    = 18;
    localparam int STEP_W   = 15;
    localparam int REM_W    = 20;
    localparam int Q_W      = 3;
    localparam int NIB_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int DELTA_W  = 16;
    localparam int NS_W     = 16;
    localparam int FACT_W   = 8;
    localparam int BIT_W    = 2;

    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;
    localparam logic [BIT_W-1:0]  TOP_BIT  = 2'd2;

    function automatic logic [FACT_W-1:0] step_factor(input logic [Q_W-1:0] q);
        logic [FACT_W-1:0] f;
        unique case (q)
            3'd4:    f = 8'd77;
            3'd5:    f = 8'd102;
            3'd6:    f = 8'd128;
            3'd7:    f = 8'd153;
            default: f = 8'd57;
        endcase
        return f;
    endfunction

    typedef struct packed {
        logic             load;
        logic             diff;
        logic             div;
        logic [BIT_W-1:0] div_bit;
        logic             mul;
        logic             upd;
    } dp_cmd_t;

    typedef struct packed {
        logic odd;
    } dp_status_t;

endpackage

### rtl/adpcm_b_delta_encoder.sv
// ADPCM-B delta encoder: 16-bit signed PCM in, packed 4-bit codes out.
//
// Input channel: sample, last_sample with sample_valid / sample_stall. A beat
// is taken when sample_valid is high and sample_stall is low.
// Output channel: adpcm_byte with byte_valid / byte_stall. One byte comes out
// for every second sample of a block, the earlier code in the high nibble.
// A sample with last_sample set ends the block: state returns to reset and a
// code left without a partner is dropped.
//
// Timing: a sample passes through accept, difference, three quotient steps,
// multiply and update. A byte is registered in the update step of the sample
// that completes it. The next sample is accepted while that byte waits.
// If the receiver stalls, the byte holds; a following byte-completing sample
// waits in its update step until the output register frees.
// Reset: predictor 0, step size 127, no pending code, output empty.
module adpcm_b_delta_encoder
    import adpcmb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_sample,
    output logic                       byte_valid,
    input  logic                       byte_stall,
    output logic [BYTE_W-1:0]          adpcm_byte
);

    dp_cmd_t    cmd;
    dp_status_t status;

    adpcmb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .status       (status),
        .cmd          (cmd)
    );

    adpcmb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (sample),
        .last_sample (last_sample),
        .status      (status),
        .adpcm_byte  (adpcm_byte)
    );

endmodule

### rtl/adpcmb_datapath.sv
module adpcmb_datapath
    import adpcmb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_sample,
    output dp_status_t                 status,
    output logic [BYTE_W-1:0]          adpcm_byte
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;
    logic [PRED_W-1:0]   pred_reg,    pred_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic [NIB_W-1:0]    pending_reg, pending_next;
    logic                odd_reg,     odd_next;
    logic                neg_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic [NS_W-1:0]     ns_reg;
    logic [BYTE_W-1:0]   byte_reg;

    logic [DIFF_W-1:0]   diff;
    logic [MAG_W-1:0]    mag;
    logic [REM_W-1:0]    rem4;
    logic [REM_W-1:0]    step8;
    logic [REM_W-1:0]    trial;
    logic [DIFF_W-1:0]   dprod;
    logic [22:0]         nprod;
    logic [NIB_W-1:0]    code;

    always_comb
    begin
        diff  = {{(DIFF_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg}
              - {pred_reg[PRED_W-1], pred_reg};
        mag   = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        rem4  = {mag, 2'b00};
        step8 = {2'b00, step_reg, 3'b000};
        trial = REM_W'({5'b00000, step_reg}) << cmd.div_bit;
        dprod = DIFF_W'({q_reg, 1'b1}) * DIFF_W'(step_reg);
        nprod = 23'(step_factor(q_reg)) * 23'(step_reg);
        code  = {neg_reg, q_reg};
    end

    always_comb
    begin
        pred_next    = neg_reg ? pred_reg - PRED_W'(delta_reg) : pred_reg + PRED_W'(delta_reg);
        if (ns_reg < NS_W'(STEP_MIN))
            step_next = STEP_MIN;
        else if (ns_reg > NS_W'(STEP_MAX))
            step_next = STEP_MAX;
        else
            step_next = ns_reg[STEP_W-1:0];
        pending_next = odd_reg ? pending_reg : code;
        odd_next     = !odd_reg;
        if (last_reg)
        begin
            pred_next    = '0;
            step_next    = STEP_MIN;
            pending_next = '0;
            odd_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg    <= '0;
            step_reg    <= STEP_MIN;
            pending_reg <= '0;
            odd_reg     <= 1'b0;
        end
        else if (cmd.upd)
        begin
            pred_reg    <= pred_next;
            step_reg    <= step_next;
            pending_reg <= pending_next;
            odd_reg     <= odd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
        end
        if (cmd.diff)
        begin
            neg_reg <= diff[DIFF_W-1];
            rem_reg <= rem4;
            q_reg   <= (rem4 >= step8) ? 3'd7 : 3'd0;
        end
        if (cmd.div && q_reg != 3'd7 && rem_reg >= trial)
        begin
            rem_reg          <= rem_reg - trial;
            q_reg[cmd.div_bit] <= 1'b1;
        end
        if (cmd.mul)
        begin
            delta_reg <= dprod[DIFF_W-1:3];
            ns_reg    <= nprod[21:6];
        end
        if (cmd.upd && odd_reg)
            byte_reg <= {pending_reg, code};
    end

    assign status.odd = odd_reg;
    assign adpcm_byte = byte_reg;

endmodule

### rtl/adpcmb_ctrl.sv
module adpcmb_ctrl
    import adpcmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    output logic       byte_valid,
    input  logic       byte_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_MUL,
        S_UPD
    } state_t;

    state_t           state_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             byte_valid_reg;

    always_comb
    begin
        cmd.load    = (state_reg == S_IDLE) && sample_valid;
        cmd.diff    = (state_reg == S_DIFF);
        cmd.div     = (state_reg == S_DIV);
        cmd.div_bit = bit_reg;
        cmd.mul     = (state_reg == S_MUL);
        cmd.upd     = (state_reg == S_UPD) && !(status.odd && byte_valid_reg && byte_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_reg        <= TOP_BIT;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd && status.odd)
                byte_valid_reg <= 1'b1;
            else if (!byte_stall)
                byte_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                        state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    bit_reg   <= TOP_BIT;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (cmd.upd)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign byte_valid   = byte_valid_reg;

    // a finished byte is never overwritten while the receiver holds it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd && status.odd) |-> !(byte_valid_reg && byte_stall))
        else $error("byte overwritten while stalled");

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("second sample accepted during encode");

    // quotient loop always runs from the top bit
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |=> (state_reg == S_DIV && bit_reg == TOP_BIT))
        else $error("quotient loop did not start at top bit");

    // a new byte shows up only right after an update beat
    a_byte_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(byte_valid_reg) |-> $past(cmd.upd && status.odd))
        else $error("byte valid without update");

endmodule

### tb/adpcm_b_delta_encoder_test.sv
`timescale 1ns / 1ps

module adpcm_b_delta_encoder_test;
    import adpcmb_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS       = 600;
    localparam int IDLE_PCT    = 34;
    localparam int Q_MAX       = 7;
    localparam int CODE_SIGN   = 3;
    localparam int SCALE_SHIFT = 6;
    localparam int S_MAX       = 32767;
    localparam int S_MIN       = -32768;
    localparam int STEP_SCALE [8] = '{57, 57, 57, 57, 77, 102, 128, 153};

    localparam int N_DIRECTED = 22;
    localparam logic signed [SAMPLE_W-1:0] DIRECTED [N_DIRECTED] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
        16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
        16'sd0, 16'sd0, 16'sd100,
        -16'sd32768,
        16'sd5, -16'sd5, 16'sd32767,
        -16'sd32768, -16'sd1
    };
    localparam bit DIRECTED_LAST [N_DIRECTED] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
        1,
        0, 0, 1,
        0, 1
    };

    typedef enum int {WAVE_NOISE, WAVE_WALK, WAVE_EXTREME, WAVE_SWING} wave_t;

    // Encoder state and the bytes it has yet to see.
    class adpcm_scoreboard;
        logic signed [PRED_W-1:0] pred;
        logic [STEP_W-1:0]        step;
        logic [NIB_W-1:0]         held_code;
        bit                       odd;
        logic [BYTE_W-1:0]        byte_q[$];
        int errors, samples, blocks, bytes_ok, dropped;

        function new();
            restart();
        endfunction

        function void restart();
            pred = '0;
            step = STEP_MIN;
            held_code = '0;
            odd = 1'b0;
        endfunction

        function int pending();
            return byte_q.size();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
            int diff, mag, q, delta, ns;
            logic [NIB_W-1:0] code;
            diff = int'(s) - int'(pred);
            mag = (diff < 0) ? -diff : diff;
            q = (4 * mag) / int'(step);
            if (q > Q_MAX)
                q = Q_MAX;
            delta = ((2 * q + 1) * int'(step)) >> 3;
            code = q[NIB_W-1:0];
            if (diff < 0)
            begin
                code[CODE_SIGN] = 1'b1;
                pred = pred - delta[PRED_W-1:0];
            end
            else
            begin
                pred = pred + delta[PRED_W-1:0];
            end
            ns = (STEP_SCALE[q] * int'(step)) >> SCALE_SHIFT;
            if (ns < int'(STEP_MIN))
                ns = int'(STEP_MIN);
            else if (ns > int'(STEP_MAX))
                ns = int'(STEP_MAX);
            step = ns[STEP_W-1:0];
            samples++;
            if (!odd)
            begin
                held_code = code;
                odd = 1'b1;
            end
            else
            begin
                byte_q.push_back({held_code, code});
                odd = 1'b0;
            end
            if (last)
            begin
                if (odd)
                    dropped++;
                blocks++;
                restart();
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (byte_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %02h", $time, got);
                return;
            end
            want = byte_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: adpcm_byte mismatch, expected %02h, actual %02h",
                         $time, want, got);
            end
            else
            begin
                bytes_ok++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
    logic                       byte_valid;
    logic                       byte_stall;
    logic [BYTE_W-1:0]          adpcm_byte;

    adpcm_scoreboard sb = new();
    bit tx_noise = 1'b1;
    bit rx_noise = 1'b1;
    bit hold_req = 1'b0;
    int cycles = 0;
    int sent = 0;
    logic signed [SAMPLE_W-1:0] last_sent = '0;

    adpcm_b_delta_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .last_sample  (last_sample),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .adpcm_byte   (adpcm_byte)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                sb.note_sample(sample, last_sample);
            if (byte_valid && !byte_stall)
                sb.check_byte(adpcm_byte);
        end
    end

    // receiver: random stalls, or one long hold when asked
    initial
    begin
        byte_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                byte_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            byte_stall <= rx_noise && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        while (tx_noise && ($urandom_range(99) < IDLE_PCT))
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        last_sample <= last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        last_sent = s;
        sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] next_sample(wave_t kind);
        int v;
        case (kind)
            WAVE_NOISE:   v = int'($signed(16'($urandom)));
            WAVE_WALK:    v = int'(last_sent) + $urandom_range(1024) - 512;
            WAVE_EXTREME:
            begin
                case ($urandom_range(3))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default:      v = int'(last_sent) + $urandom_range(16384) - 8192;
        endcase
        if (v > S_MAX)
            v = S_MAX;
        else if (v < S_MIN)
            v = S_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_block(int len, wave_t kind);
        for (int i = 0; i < len; i++)
            push_sample(next_sample(kind), i == len - 1);
    endtask

    task automatic send_random(int stop_at);
        int len;
        while (sent < stop_at)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
            send_block(len, wave_t'($urandom_range(3)));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        last_sample <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            push_sample(DIRECTED[i], DIRECTED_LAST[i]);

        send_random(250);

        // long output hold while input keeps coming; block must back up
        tx_noise = 1'b0;
        hold_req = 1'b1;
        send_block(40, WAVE_SWING);
        sample_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // no idling on either side
        rx_noise = 1'b0;
        send_random(sent + 100);
        rx_noise = 1'b1;
        tx_noise = 1'b1;

        send_random(ITEMS);
        sample_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d samples in %0d blocks, %0d bytes matched, %0d odd codes dropped",
                 sb.samples, sb.blocks, sb.bytes_ok, sb.dropped);
        $display("includes a %0d-cycle output hold with input backpressure", HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
